// ===== rtl/core/lfuc_pkg.sv =====
// shared types and constants for the lfu cache core
// no dependencies; imported by lfuc_ctrl, lfuc_dpath and the top level
package lfuc_pkg;

   localparam int CAPACITY  = 64;
   localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int DATA_W    = 32;
   localparam int CAP_REG_W = 7;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CAP_REG_W-1:0] CAP_RESET   = 7'd64;
   localparam logic [DATA_W-1:0]    MISS_VALUE  = 32'hFFFF_FFFF;
   localparam logic                 MODE_GET    = 1'b0;
   localparam logic                 MODE_PUT    = 1'b1;
   localparam logic                 REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
      logic [DATA_W-1:0] use_count;
      logic [DATA_W-1:0] stamp;
   } slot_word_type;

   localparam int SLOT_W = $bits(slot_word_type);

   typedef struct packed {
      logic             load;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             commit;
   } lfuc_cmd_type;

   typedef struct packed {
      logic is_get;
      logic rsp_free;
   } lfuc_stat_type;

   function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] x);
      sat_inc = (x == {DATA_W{1'b1}}) ? x : x + DATA_W'(1);
   endfunction

endpackage

// ===== rtl/core/lfuc_if.sv =====
// request and response channel interfaces for the lfu cache core
// depends on lfuc_pkg for field widths
interface lfuc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic signed [lfuc_pkg::DATA_W-1:0] key;
   logic signed [lfuc_pkg::DATA_W-1:0] value;

   modport source (output valid, output mode, output key, output value, input ready);
   modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lfuc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               hit;
   logic signed [lfuc_pkg::DATA_W-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink (input valid, input hit, input read_value, output ready);
endinterface

// ===== rtl/core/lfuc_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module lfuc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/lfuc_ctrl.sv =====
// sequencer for the lfu cache core: accept, slot scan, drain, commit
// depends on lfuc_pkg for command and status types
module lfuc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lfuc_pkg::lfuc_stat_type stat,
   output lfuc_pkg::lfuc_cmd_type  cmd
);
   import lfuc_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] scan_ff, scan_in;

   always_comb begin
      state_in  = state_ff;
      scan_in   = scan_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               scan_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = scan_ff;
            scan_in     = scan_ff + IDX_W'(1);
            if (scan_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!stat.is_get || stat.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         scan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
      end
   end
endmodule

// ===== rtl/core/lfuc_dpath.sv =====
// datapath of the lfu cache core: item latch, slot ram, scan trackers,
// valid map, occupancy, touch clock and response register; uses lfuc_pkg, lfuc_ram
module lfuc_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  lfuc_pkg::lfuc_cmd_type              cmd,
   output lfuc_pkg::lfuc_stat_type             stat,
   input  logic [lfuc_pkg::CAP_REG_W-1:0]      capacity_in_use,
   input  logic                                req_mode,
   input  logic [lfuc_pkg::DATA_W-1:0]         req_key,
   input  logic [lfuc_pkg::DATA_W-1:0]         req_value,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic [lfuc_pkg::DATA_W-1:0]         rsp_read_value
);
   import lfuc_pkg::*;

   localparam int CMP_W = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;

   // latched item
   logic              mode_ff, mode_in;
   logic [DATA_W-1:0] key_ff, key_in;
   logic [DATA_W-1:0] value_ff, value_in;

   // read pipeline
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;

   // scan trackers
   logic              match_found_ff, match_found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic [DATA_W-1:0] match_cnt_ff, match_cnt_in;
   logic [DATA_W-1:0] match_val_ff, match_val_in;
   logic              victim_found_ff, victim_found_in;
   logic [IDX_W-1:0]  victim_idx_ff, victim_idx_in;
   logic [DATA_W-1:0] victim_cnt_ff, victim_cnt_in;
   logic [DATA_W-1:0] victim_stamp_ff, victim_stamp_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;

   // store state
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic [DATA_W-1:0]   touch_ff, touch_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [DATA_W-1:0] rsp_value_ff, rsp_value_in;

   // ram
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   slot_word_type     wr_word;
   logic [SLOT_W-1:0] rd_data;
   slot_word_type     rd_word;
   logic              cur_valid;

   // commit decisions
   logic [CMP_W-1:0]  cap_wide;
   logic [CNT_W-1:0]  cap_eff;
   logic              do_evict;
   logic [IDX_W-1:0]  ins_slot;
   logic [DATA_W-1:0] touch_next;

   lfuc_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (CAPACITY)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   assign rd_word   = slot_word_type'(rd_data);
   assign cur_valid = valid_ff[rd_idx_ff];

   assign stat.is_get   = (mode_ff == MODE_GET);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   assign cap_wide   = CMP_W'(capacity_in_use);
   assign cap_eff    = (cap_wide > CMP_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cap_wide);
   assign touch_next = sat_inc(touch_ff);
   assign do_evict   = victim_found_ff && ((occ_ff >= cap_eff) || !free_found_ff);
   assign ins_slot   = !do_evict ? free_idx_ff :
                       (free_found_ff && (free_idx_ff < victim_idx_ff)) ? free_idx_ff :
                       victim_idx_ff;

   // item latch and scan
   always_comb begin
      mode_in         = mode_ff;
      key_in          = key_ff;
      value_in        = value_ff;
      rd_vld_in       = cmd.rd_en;
      rd_idx_in       = cmd.rd_addr;
      match_found_in  = match_found_ff;
      match_idx_in    = match_idx_ff;
      match_cnt_in    = match_cnt_ff;
      match_val_in    = match_val_ff;
      victim_found_in = victim_found_ff;
      victim_idx_in   = victim_idx_ff;
      victim_cnt_in   = victim_cnt_ff;
      victim_stamp_in = victim_stamp_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      if (cmd.load) begin
         mode_in         = req_mode;
         key_in          = req_key;
         value_in        = req_value;
         match_found_in  = 1'b0;
         victim_found_in = 1'b0;
         free_found_in   = 1'b0;
      end else if (rd_vld_ff) begin
         if (cur_valid && (rd_word.key == key_ff) && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = rd_idx_ff;
            match_cnt_in   = rd_word.use_count;
            match_val_in   = rd_word.value;
         end
         // lowest count, then oldest stamp; first slot wins a full tie
         if (cur_valid && (!victim_found_ff ||
             ({rd_word.use_count, rd_word.stamp} < {victim_cnt_ff, victim_stamp_ff}))) begin
            victim_found_in = 1'b1;
            victim_idx_in   = rd_idx_ff;
            victim_cnt_in   = rd_word.use_count;
            victim_stamp_in = rd_word.stamp;
         end
         if (!cur_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end
   end

   // commit: slot write, valid map, occupancy, touch clock, response
   always_comb begin
      wr_en        = 1'b0;
      wr_addr      = match_idx_ff;
      wr_word      = '{key: key_ff, value: value_ff,
                       use_count: sat_inc(match_cnt_ff), stamp: touch_ff};
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      touch_in     = touch_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      if (cmd.commit) begin
         if (mode_ff == MODE_GET) begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = match_found_ff;
            rsp_value_in = match_found_ff ? match_val_ff : MISS_VALUE;
            if (match_found_ff) begin
               wr_en         = 1'b1;
               wr_word.value = match_val_ff;
               touch_in      = touch_next;
            end
         end else if (cap_eff != '0) begin
            wr_en    = 1'b1;
            touch_in = touch_next;
            if (!match_found_ff) begin
               wr_addr           = ins_slot;
               wr_word.use_count = DATA_W'(1);
               if (do_evict) begin
                  valid_in[victim_idx_ff] = 1'b0;
               end else begin
                  occ_in = occ_ff + CNT_W'(1);
               end
               valid_in[ins_slot] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff         <= mode_in;
      key_ff          <= key_in;
      value_ff        <= value_in;
      rd_idx_ff       <= rd_idx_in;
      match_idx_ff    <= match_idx_in;
      match_cnt_ff    <= match_cnt_in;
      match_val_ff    <= match_val_in;
      victim_idx_ff   <= victim_idx_in;
      victim_cnt_ff   <= victim_cnt_in;
      victim_stamp_ff <= victim_stamp_in;
      free_idx_ff     <= free_idx_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_value_ff    <= rsp_value_in;
      if (reset) begin
         rd_vld_ff       <= 1'b0;
         match_found_ff  <= 1'b0;
         victim_found_ff <= 1'b0;
         free_found_ff   <= 1'b0;
         valid_ff        <= '0;
         occ_ff          <= '0;
         touch_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rd_vld_ff       <= rd_vld_in;
         match_found_ff  <= match_found_in;
         victim_found_ff <= victim_found_in;
         free_found_ff   <= free_found_in;
         valid_ff        <= valid_in;
         occ_ff          <= occ_in;
         touch_ff        <= touch_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   // occupancy always tracks the number of valid slots
   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(occ_ff))
      else $error("occupancy out of step with valid map");

   // a lookup commit never overwrites an unclaimed response
   a_commit_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && mode_ff == MODE_GET) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");

   // a lookup commit always presents a response next cycle
   a_get_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && mode_ff == MODE_GET) |=> rsp_valid_ff)
      else $error("lookup produced no response");

   // the touch clock only moves forward
   a_touch_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> touch_ff >= $past(touch_ff))
      else $error("touch clock went backward");
endmodule

// ===== rtl/core/lfu_cache_lru_tiebreak_core.sv =====
// top level of the lfu cache core with lru tie break
// depends on lfuc_pkg, lfuc_if, lfuc_ram, lfuc_ctrl, lfuc_dpath
//
//  channel | dir | handshake           | word
//  --------+-----+---------------------+---------------------------------
//  req     | in  | valid / ready       | mode, key, value
//  rsp     | out | valid / ready       | hit, read_value (one per get)
//  csr     | in  | apb psel / penable  | capacity_in_use at address 0
//
// an item passes through four steps: accept, a scan that streams every slot out of
// the slot ram (one read port, one slot a cycle), a drain of the read
// register and a commit of the update
// a get commit waits while the previous response word is still unclaimed;
// a new item is accepted while a response word waits
// reset clears the valid map, occupancy, touch clock and all control;
// capacity_in_use returns to 64
module lfu_cache_lru_tiebreak_core (
   input  logic                                clock,
   input  logic                                reset,
   lfuc_req_if.sink                            req_chan,
   lfuc_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [lfuc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [lfuc_pkg::CSR_W-1:0]          csr_pwdata,
   output logic [lfuc_pkg::CSR_W-1:0]          csr_prdata,
   output logic                                csr_pready
);
   import lfuc_pkg::*;

   // capacity register
   logic [CAP_REG_W-1:0] cap_ff, cap_in;
   logic                 csr_wr;
   logic                 csr_reg_idx;

   lfuc_cmd_type  cmd;
   lfuc_stat_type stat;
   logic          req_ready;

   // register index is the word address above the byte offset
   assign csr_reg_idx = csr_paddr[CSR_ADDR_W-1];
   assign csr_pready  = 1'b1;
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cap_in = cap_ff;
      if (csr_wr && (csr_reg_idx == REG_CAPACITY)) begin
         cap_in = csr_pwdata[CAP_REG_W-1:0];
      end
   end

   // read back: the capacity register, zero elsewhere
   assign csr_prdata = (csr_reg_idx == REG_CAPACITY) ? CSR_W'(cap_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // sequencer: accept, scan, drain, commit
   lfuc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // slot store, scan trackers and response register
   lfuc_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .capacity_in_use (cap_ff),
      .req_mode        (req_chan.mode),
      .req_key         (req_chan.key),
      .req_value       (req_chan.value),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_hit         (rsp_chan.hit),
      .rsp_read_value  (rsp_chan.read_value)
   );
endmodule
